// ----- hdl/rsi_pkg.sv -----
`default_nettype none

package rsi_pkg;

   localparam int ECHO_BITS      = 16;
   localparam int THRESHOLD_BITS = 11;
   localparam int DEBOUNCE_BITS  = 24;
   localparam int TIMEOUT_BITS   = 16;
   localparam int DIST_BITS      = 11;
   localparam int DIST_OUT_BITS  = 12;

   // distance = floor(echo * 343 / 20000), done as echo * ceil(343 * 2^31 / 20000) >> 31;
   // exact across the whole 16-bit echo range
   localparam int                  RECIP_BITS = 26;
   localparam int                  DIST_SHIFT = 31;
   localparam int                  PROD_BITS  = ECHO_BITS + RECIP_BITS;
   localparam logic [RECIP_BITS-1:0] DIST_RECIP = 26'd36829345;

   localparam logic [THRESHOLD_BITS-1:0] THRESHOLD_RESET = 11'd30;
   localparam logic [DEBOUNCE_BITS-1:0]  DEBOUNCE_RESET  = 24'd200000;
   localparam logic [TIMEOUT_BITS-1:0]   TIMEOUT_RESET   = 16'd30000;

   typedef enum logic [1:0] {
      KIND_ECHO    = 2'd0,
      KIND_TIMEOUT = 2'd1,
      KIND_ESTOP   = 2'd2,
      KIND_TICK    = 2'd3
   } req_kind_type;

   typedef struct packed {
      logic [THRESHOLD_BITS-1:0] threshold_cm;
      logic [DEBOUNCE_BITS-1:0]  debounce_us;
      logic [TIMEOUT_BITS-1:0]   echo_timeout_us;
   } cfg_type;

   typedef struct packed {
      req_kind_type          kind;
      logic [DIST_BITS-1:0]  range_cm;
   } item_type;

endpackage

`default_nettype wire

// ----- hdl/rsi_csr.sv -----
`default_nettype none

module rsi_csr
   import rsi_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready,
   output cfg_type          cfg
);

   localparam logic [1:0] REG_THRESHOLD = 2'd0;
   localparam logic [1:0] REG_DEBOUNCE  = 2'd1;
   localparam logic [1:0] REG_TIMEOUT   = 2'd2;

   cfg_type    cfg_ff;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[3:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold_cm    <= THRESHOLD_RESET;
         cfg_ff.debounce_us     <= DEBOUNCE_RESET;
         cfg_ff.echo_timeout_us <= TIMEOUT_RESET;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_THRESHOLD: cfg_ff.threshold_cm    <= csr_pwdata[THRESHOLD_BITS-1:0];
            REG_DEBOUNCE:  cfg_ff.debounce_us     <= csr_pwdata[DEBOUNCE_BITS-1:0];
            REG_TIMEOUT:   cfg_ff.echo_timeout_us <= csr_pwdata[TIMEOUT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_THRESHOLD: csr_prdata = {{(32-THRESHOLD_BITS){1'b0}}, cfg_ff.threshold_cm};
         REG_DEBOUNCE:  csr_prdata = {{(32-DEBOUNCE_BITS){1'b0}}, cfg_ff.debounce_us};
         REG_TIMEOUT:   csr_prdata = {{(32-TIMEOUT_BITS){1'b0}}, cfg_ff.echo_timeout_us};
         default:       csr_prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

// ----- hdl/rsi_front.sv -----
`default_nettype none

module rsi_front
   import rsi_pkg::*;
#(
   parameter int TIME_BITS = 48
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [1:0]             req_type,
   input  wire logic [ECHO_BITS-1:0]   req_echo_us,
   input  wire logic [TIME_BITS-1:0]   req_now_us,
   input  wire logic [TIMEOUT_BITS-1:0] echo_timeout_us,
   input  wire logic                   take,
   output logic                        item_valid,
   output item_type                    item,
   output logic      [TIME_BITS-1:0]   item_now_us
);

   logic                   valid_ff;
   logic                   valid_in;
   item_type               item_ff;
   item_type               item_in;
   logic [TIME_BITS-1:0]   now_ff;
   logic [PROD_BITS-1:0]   prod;
   logic                   accept;
   req_kind_type           kind;

   assign req_ready   = !valid_ff || take;
   assign accept      = req_valid && req_ready;
   assign valid_in    = accept || (valid_ff && !take);
   assign item_valid  = valid_ff;
   assign item        = item_ff;
   assign item_now_us = now_ff;

   assign kind = req_kind_type'(req_type);
   assign prod = PROD_BITS'(req_echo_us) * PROD_BITS'(DIST_RECIP);

   always_comb begin
      item_in.range_cm = prod[DIST_SHIFT +: DIST_BITS];
      // an echo beyond the limit behaves exactly like a sensor timeout
      if (kind == KIND_ECHO && req_echo_us > echo_timeout_us) begin
         item_in.kind = KIND_TIMEOUT;
      end else begin
         item_in.kind = kind;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         item_ff <= item_in;
         now_ff  <= req_now_us;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/rsi_core.sv -----
`default_nettype none

module rsi_core
   import rsi_pkg::*;
#(
   parameter int TIME_BITS = 48
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire cfg_type                     cfg,
   input  wire logic                        item_valid,
   input  wire item_type                    item,
   input  wire logic [TIME_BITS-1:0]        item_now_us,
   output logic                             take,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic      [1:0]                  rsp_ride_state,
   output logic                             rsp_brake_on,
   output logic                             rsp_all_clear_on,
   output logic signed [DIST_OUT_BITS-1:0]  rsp_range_cm,
   output logic                             rsp_obstruction
);

   typedef enum logic [1:0] {
      MODE_CLEAR   = 2'd0,
      MODE_PROX    = 2'd1,
      MODE_ESTOP   = 2'd2,
      MODE_RESTART = 2'd3
   } mode_type;

   mode_type                        mode_ff, mode_in;
   logic                            obs_ff, obs_in;
   logic                            prev_obs_ff, prev_obs_in;
   logic                            prox_pend_ff, prox_pend_in;
   logic                            estop_pend_ff, estop_pend_in;
   logic [TIME_BITS-1:0]            last_estop_ff, last_estop_in;
   logic signed [DIST_OUT_BITS-1:0] dist_ff, dist_in;

   logic                            rsp_valid_ff;
   logic [1:0]                      state_out_ff;
   logic                            brake_ff;
   logic                            clear_ff;
   logic signed [DIST_OUT_BITS-1:0] dist_out_ff;
   logic                            obs_out_ff;

   logic [TIME_BITS-1:0]            gap;
   logic                            edge_ok;
   logic                            near;

   assign take = item_valid && (!rsp_valid_ff || rsp_ready);

   // wrap-around gap between e-stop edges
   assign gap     = item_now_us - last_estop_ff;
   assign edge_ok = gap > {{(TIME_BITS-DEBOUNCE_BITS){1'b0}}, cfg.debounce_us};
   assign near    = (item.range_cm != '0) && (item.range_cm < cfg.threshold_cm);

   always_comb begin
      mode_in       = mode_ff;
      obs_in        = obs_ff;
      prev_obs_in   = prev_obs_ff;
      prox_pend_in  = prox_pend_ff;
      estop_pend_in = estop_pend_ff;
      last_estop_in = last_estop_ff;
      dist_in       = dist_ff;
      unique case (item.kind)
         KIND_ECHO: begin
            dist_in     = {1'b0, item.range_cm};
            obs_in      = near;
            prev_obs_in = near;
            if (near && !prev_obs_ff) begin
               prox_pend_in = 1'b1;
            end
         end
         KIND_TIMEOUT: begin
            obs_in  = 1'b1;
            dist_in = '1;
         end
         KIND_ESTOP: begin
            if (edge_ok) begin
               last_estop_in = item_now_us;
               estop_pend_in = 1'b1;
            end
         end
         KIND_TICK: begin
            // rules apply in order, each seeing the mode left by the one before
            if ((mode_in == MODE_CLEAR || mode_in == MODE_RESTART) && prox_pend_in) begin
               prox_pend_in = 1'b0;
               mode_in      = MODE_PROX;
            end
            if (estop_pend_in) begin
               estop_pend_in = 1'b0;
               if (mode_in == MODE_CLEAR || mode_in == MODE_PROX) begin
                  mode_in = MODE_ESTOP;
               end else if (!obs_ff) begin
                  mode_in = MODE_CLEAR;
               end
            end
            if (mode_in == MODE_PROX && !obs_ff) begin
               mode_in = MODE_RESTART;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_CLEAR;
         obs_ff        <= 1'b0;
         prev_obs_ff   <= 1'b0;
         prox_pend_ff  <= 1'b0;
         estop_pend_ff <= 1'b0;
         last_estop_ff <= '0;
         dist_ff       <= '1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= take || (rsp_valid_ff && !rsp_ready);
         if (take) begin
            mode_ff       <= mode_in;
            obs_ff        <= obs_in;
            prev_obs_ff   <= prev_obs_in;
            prox_pend_ff  <= prox_pend_in;
            estop_pend_ff <= estop_pend_in;
            last_estop_ff <= last_estop_in;
            dist_ff       <= dist_in;
         end
      end
      if (take) begin
         state_out_ff <= mode_in;
         brake_ff     <= (mode_in != MODE_CLEAR);
         clear_ff     <= (mode_in == MODE_CLEAR);
         dist_out_ff  <= dist_in;
         obs_out_ff   <= obs_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ride_state   = state_out_ff;
   assign rsp_brake_on     = brake_ff;
   assign rsp_all_clear_on = clear_ff;
   assign rsp_range_cm     = dist_out_ff;
   assign rsp_obstruction  = obs_out_ff;

endmodule

`default_nettype wire

// ----- hdl/ride_safety_interlock.sv -----
`default_nettype none

// Ride safety interlock. Every item on the req_ channel gives exactly one result on the
// rsp_ channel: the ride state, brake and all-clear lamps, the latest distance (-1 after a
// sensor timeout) and the obstruction flag, all as they stand after that item. One item is
// taken every clock cycle unless a result waits with rsp_ready low. The echo-to-distance
// multiply sits in front of the input register, and the state update feeds the result
// register. The result register holds a waiting result while the next item is still
// accepted into the input register. The user writes configuration through the csr_ port
// only while no item is in flight; the block itself does not enforce this.

module ride_safety_interlock
   import rsi_pkg::*;
#(
   parameter int TIME_BITS = 48
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [1:0]                  req_type,
   input  wire logic [ECHO_BITS-1:0]        req_echo_us,
   input  wire logic [TIME_BITS-1:0]        req_now_us,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic      [1:0]                  rsp_ride_state,
   output logic                             rsp_brake_on,
   output logic                             rsp_all_clear_on,
   output logic signed [DIST_OUT_BITS-1:0]  rsp_range_cm,
   output logic                             rsp_obstruction,
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [3:0]                  csr_paddr,
   input  wire logic [31:0]                 csr_pwdata,
   output logic      [31:0]                 csr_prdata,
   output logic                             csr_pready
);

   cfg_type              cfg;
   logic                 take;
   logic                 item_valid;
   item_type             item;
   logic [TIME_BITS-1:0] item_now_us;

   rsi_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   rsi_front #(
      .TIME_BITS (TIME_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_echo_us     (req_echo_us),
      .req_now_us      (req_now_us),
      .echo_timeout_us (cfg.echo_timeout_us),
      .take            (take),
      .item_valid      (item_valid),
      .item            (item),
      .item_now_us     (item_now_us)
   );

   rsi_core #(
      .TIME_BITS (TIME_BITS)
   ) u_core (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .item_valid       (item_valid),
      .item             (item),
      .item_now_us      (item_now_us),
      .take             (take),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_ride_state   (rsp_ride_state),
      .rsp_brake_on     (rsp_brake_on),
      .rsp_all_clear_on (rsp_all_clear_on),
      .rsp_range_cm     (rsp_range_cm),
      .rsp_obstruction  (rsp_obstruction)
   );

endmodule

`default_nettype wire
